[rtl/core/ket_pkg.sv]
// shared widths, command and status codes for the keyed entry table
package ket_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int WORD_W = 64;
  localparam int KEY_WORDS = 4;
  localparam int KEY_W = WORD_W * KEY_WORDS;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 5;

  localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_W-1:0] key_t;

endpackage

[rtl/core/keyed_entry_table_top.sv]
// keyed entry table: register, lookup and swap-remove over a scanned key store
//
// One command is in flight at a time; in_ready is high only while the sequencer
// is idle. A command is accepted, then the keys are scanned at one stored entry
// per cycle, the key memory read port being the limit; on a hit a fetch state
// reads the matched entry and an apply state updates it, and a done state then
// loads the output register once it is free. The output register lets the next
// command be accepted while the last result still waits. Keys live in a memory
// of one 256-bit row per entry, time and payload in a second memory of one
// 128-bit row per entry; both start undefined and need no clearing, since only
// rows below the entry count are used.
module keyed_entry_table_top
  import ket_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [WORD_W-1:0]   in_key_word0,
  input  logic [WORD_W-1:0]   in_key_word1,
  input  logic [WORD_W-1:0]   in_key_word2,
  input  logic [WORD_W-1:0]   in_key_word3,
  input  logic [WORD_W-1:0]   in_publish_time,
  input  logic [WORD_W-1:0]   in_entry_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_entry_written,
  output logic [WORD_W-1:0]   out_found_time,
  output logic [WORD_W-1:0]   out_found_payload,
  output logic [OCC_W-1:0]    out_occupancy
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DATA_W = 2 * WORD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // memories
  key_t               key_mem  [TABLE_DEPTH];
  logic [DATA_W-1:0]  data_mem [TABLE_DEPTH];
  key_t               key_rdata_r;
  logic [DATA_W-1:0]  data_rdata_r;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  key_t                key_r, key_nxt;
  word_t               time_r, time_nxt;
  word_t               pay_r, pay_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_written_r, res_written_nxt;
  word_t               res_time_r, res_time_nxt;
  word_t               res_pay_r, res_pay_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_written_r, out_written_nxt;
  word_t               out_time_r, out_time_nxt;
  word_t               out_pay_r, out_pay_nxt;
  logic [OCC_W-1:0]    out_occ_r, out_occ_nxt;

  logic                key_we;
  logic [IDX_W-1:0]    key_waddr;
  key_t                key_wdata;
  logic [IDX_W-1:0]    key_raddr;
  logic                data_we;
  logic [IDX_W-1:0]    data_waddr;
  logic [DATA_W-1:0]   data_wdata;
  logic [IDX_W-1:0]    data_raddr;

  logic [CNT_W-1:0]    last_cnt;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    count_idx;
  logic                key_match;
  logic                table_full;

  assign last_cnt   = count_r - CNT_W'(1);
  assign last_idx   = last_cnt[IDX_W-1:0];
  assign count_idx  = count_r[IDX_W-1:0];
  assign key_match  = (key_rdata_r == key_r);
  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_written = out_written_r;
  assign out_found_time    = out_time_r;
  assign out_found_payload = out_pay_r;
  assign out_occupancy     = out_occ_r;

  // read addresses: scan walks the keys, fetch reads the hit slot or the last slot
  always_comb begin
    key_raddr  = idx_r[IDX_W-1:0];
    data_raddr = slot_r;
    if (state_r == S_FETCH) begin
      key_raddr = last_idx;
      if (cmd_r == CMD_REMOVE) begin
        data_raddr = last_idx;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    cmp_idx_nxt     = cmp_idx_r;
    cmp_vld_nxt     = cmp_vld_r;
    slot_nxt        = slot_r;
    cmd_nxt         = cmd_r;
    key_nxt         = key_r;
    time_nxt        = time_r;
    pay_nxt         = pay_r;
    res_status_nxt  = res_status_r;
    res_written_nxt = res_written_r;
    res_time_nxt    = res_time_r;
    res_pay_nxt     = res_pay_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_written_nxt = out_written_r;
    out_time_nxt    = out_time_r;
    out_pay_nxt     = out_pay_r;
    out_occ_nxt     = out_occ_r;
    key_we          = 1'b0;
    key_waddr       = slot_r;
    key_wdata       = key_rdata_r;
    data_we         = 1'b0;
    data_waddr      = slot_r;
    data_wdata      = data_rdata_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt         = in_command;
          key_nxt         = {in_key_word3, in_key_word2, in_key_word1, in_key_word0};
          time_nxt        = in_publish_time;
          pay_nxt         = in_entry_payload;
          idx_nxt         = '0;
          cmp_vld_nxt     = 1'b0;
          res_status_nxt  = ST_OK;
          res_written_nxt = 1'b0;
          res_time_nxt    = '0;
          res_pay_nxt     = '0;
          state_nxt       = (in_command == CMD_UNUSED) ? S_DONE : S_SCAN;
        end
      end

      S_SCAN: begin
        if (cmp_vld_r && key_match) begin
          slot_nxt  = cmp_idx_r;
          state_nxt = S_FETCH;
        end else if (idx_r == count_r) begin
          // every stored key compared without a hit
          state_nxt = S_DONE;
          if (cmd_r == CMD_REGISTER) begin
            if (table_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              key_we          = 1'b1;
              key_waddr       = count_idx;
              key_wdata       = key_r;
              data_we         = 1'b1;
              data_waddr      = count_idx;
              data_wdata      = {time_r, pay_r};
              count_nxt       = count_r + CNT_W'(1);
              res_written_nxt = 1'b1;
            end
          end else begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end else begin
          cmp_idx_nxt = idx_r[IDX_W-1:0];
          cmp_vld_nxt = 1'b1;
          idx_nxt     = idx_r + CNT_W'(1);
        end
      end

      S_FETCH: begin
        state_nxt = S_APPLY;
      end

      S_APPLY: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_REGISTER: begin
            if (time_r > data_rdata_r[DATA_W-1:WORD_W]) begin
              data_we         = 1'b1;
              data_waddr      = slot_r;
              data_wdata      = {time_r, pay_r};
              res_written_nxt = 1'b1;
            end
          end
          CMD_LOOKUP: begin
            res_time_nxt = data_rdata_r[DATA_W-1:WORD_W];
            res_pay_nxt  = data_rdata_r[WORD_W-1:0];
          end
          CMD_REMOVE: begin
            // swap the last entry into the freed slot
            if (last_idx != slot_r) begin
              key_we     = 1'b1;
              key_waddr  = slot_r;
              key_wdata  = key_rdata_r;
              data_we    = 1'b1;
              data_waddr = slot_r;
              data_wdata = data_rdata_r;
            end
            count_nxt = last_cnt;
          end
          default: begin
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_written_nxt = res_written_r;
          out_time_nxt    = res_time_r;
          out_pay_nxt     = res_pay_r;
          out_occ_nxt     = OCC_W'(count_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata_r <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_rdata_r <= data_mem[data_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    slot_r        <= slot_nxt;
    cmd_r         <= cmd_nxt;
    key_r         <= key_nxt;
    time_r        <= time_nxt;
    pay_r         <= pay_nxt;
    res_status_r  <= res_status_nxt;
    res_written_r <= res_written_nxt;
    res_time_r    <= res_time_nxt;
    res_pay_r     <= res_pay_nxt;
    out_status_r  <= out_status_nxt;
    out_written_r <= out_written_nxt;
    out_time_r    <= out_time_nxt;
    out_pay_r     <= out_pay_nxt;
    out_occ_r     <= out_occ_nxt;
  end

endmodule
